// ===== rtl/sm3_pkg.sv =====
// Package for the SM3 hash engine: block and chaining types, initial value,
// round constants and the rotate and permutation helpers.
// No dependencies.
package sm3_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int PAD_LIMIT   = 56;
   localparam int ROUNDS      = 64;

   typedef logic [15:0][31:0] sm3_block_type;
   typedef logic [7:0][31:0]  sm3_chain_type;

   typedef struct packed {
      logic start;
      logic init;
   } sm3_ctl_type;

   localparam sm3_chain_type SM3_IV = {
      32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
      32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
   };

   localparam logic [31:0] T_LOW    = 32'h79CC4519;
   localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rotl32(x, 9) ^ rotl32(x, 17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rotl32(x, 15) ^ rotl32(x, 23);
   endfunction

   // round constant rotated left by the round number (mod 32)
   function automatic logic [31:0] t_rot(input logic [5:0] j);
      logic [31:0] tj;
      logic [63:0] r;
      tj = (j < 6'd16) ? T_LOW : T_HIGH;
      r  = {tj, tj} << j[4:0];
      return r[63:32];
   endfunction

endpackage

// ===== rtl/sm3_if.sv =====
// Handshake channels of the SM3 hash engine: message words in, digest words out.
// No dependencies.
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  valid_bytes;
   logic        last;

   modport source (output valid, data_word, valid_bytes, last, input ready);
   modport sink   (input valid, data_word, valid_bytes, last, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sm3_hash_engine.sv =====
// SM3 hash engine: message words in, eight digest words out per message.
// The shared compression unit runs one round per cycle on each 64-byte block,
// and words keep arriving into the block buffer while it runs; a word waits
// only during padding or when the buffer holds 60 or more bytes while the unit
// is busy. After the last word the padded block is compressed (a second block
// when the pad spills over, after any block that the last word completed),
// then the digest moves into the output register once the earlier digest has
// drained; it drains one word per cycle while rsp ready is high, and the next
// message is already accepted meanwhile.
// Uses sm3_pkg, sm3_if and sm3_comp.
module sm3_hash_engine import sm3_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   sm3_req_if.sink          req_if,
   sm3_rsp_if.source        rsp_if
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_PAD2,
      ST_FINAL
   } state_type;

   state_type     state_ff, state_in;
   logic [5:0]    fill_ff, fill_in;
   logic [63:0]   len_ff, len_in;
   sm3_block_type buf_ff, buf_in;
   sm3_chain_type out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   logic [2:0]    out_idx_ff, out_idx_in;

   sm3_ctl_type   ctl;
   sm3_block_type comp_block, merged, pad_blk, len_blk;
   sm3_chain_type chain;
   logic          comp_busy;

   logic       accept, rsp_take, pad_fits, wraps;
   logic [2:0] cnt;
   logic [6:0] end7;

   sm3_comp u_comp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .block (comp_block),
      .busy  (comp_busy),
      .chain (chain)
   );

   assign cnt      = (req_if.valid_bytes > 3'd4) ? 3'd4 : req_if.valid_bytes;
   assign end7     = {1'b0, fill_ff} + {4'b0, cnt};
   assign wraps    = end7[6];
   assign pad_fits = fill_ff < 6'(PAD_LIMIT);

   assign req_if.ready = (state_ff == ST_IDLE) && !(comp_busy && fill_ff >= 6'd60);
   assign accept       = req_if.valid && req_if.ready;
   assign rsp_take     = rsp_if.valid && rsp_if.ready;

   // byte insertion: bytes past the block end wrap to the start of the next
   always_comb begin
      logic [5:0] off;
      logic       hit;
      logic [7:0] din;
      merged = buf_ff;
      buf_in = buf_ff;
      for (int p = 0; p < BLOCK_BYTES; p++) begin
         off = 6'(p) - fill_ff;
         hit = accept && ({3'b0, cnt} > off);
         din = req_if.data_word[8 * (3 - int'(off[1:0])) +: 8];
         if (hit) begin
            buf_in[p / 4][8 * (3 - p % 4) +: 8] = din;
            if (6'(p) >= fill_ff) begin
               merged[p / 4][8 * (3 - p % 4) +: 8] = din;
            end
         end
      end
   end

   always_comb begin
      pad_blk = '0;
      for (int p = 0; p < BLOCK_BYTES; p++) begin
         if (6'(p) < fill_ff) begin
            pad_blk[p / 4][8 * (3 - p % 4) +: 8] = buf_ff[p / 4][8 * (3 - p % 4) +: 8];
         end else if (6'(p) == fill_ff) begin
            pad_blk[p / 4][8 * (3 - p % 4) +: 8] = PAD_BYTE;
         end
      end
      if (pad_fits) begin
         pad_blk[14] = len_ff[63:32];
         pad_blk[15] = len_ff[31:0];
      end
      len_blk     = '0;
      len_blk[14] = len_ff[63:32];
      len_blk[15] = len_ff[31:0];
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      ctl          = '0;
      comp_block   = merged;

      if (rsp_take) begin
         out_in     = {32'h0, out_ff[7:1]};
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == 3'd7) begin
            out_valid_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in   = end7[5:0];
               len_in    = len_ff + {58'b0, cnt, 3'b0};
               ctl.start = wraps;
               if (req_if.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            comp_block = pad_blk;
            if (!comp_busy) begin
               ctl.start = 1'b1;
               state_in  = pad_fits ? ST_FINAL : ST_PAD2;
            end
         end
         ST_PAD2: begin
            comp_block = len_blk;
            if (!comp_busy) begin
               ctl.start = 1'b1;
               state_in  = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (!comp_busy && !out_valid_ff) begin
               ctl.init     = 1'b1;
               out_in       = chain;
               out_valid_in = 1'b1;
               out_idx_in   = '0;
               fill_in      = '0;
               len_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
      buf_ff <= buf_in;
      out_ff <= out_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.digest_word = out_ff[0];
   assign rsp_if.word_index  = out_idx_ff;
   assign rsp_if.last_word   = (out_idx_ff == 3'd7);

endmodule

// ===== rtl/sm3_comp.sv =====
// SM3 compression unit: one round per cycle over the 64 rounds, message expansion
// in a 16-word sliding window, chaining value held here. Uses sm3_pkg.
module sm3_comp import sm3_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sm3_ctl_type   ctl,
   input  sm3_block_type block,
   output logic          busy,
   output sm3_chain_type chain
);

   sm3_chain_type chain_ff, chain_in;
   sm3_chain_type work_ff, work_in;
   sm3_block_type win_ff, win_in;
   logic          busy_ff, busy_in;
   logic [5:0]    round_ff, round_in;

   logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, w_new;

   always_comb begin
      a12 = rotl32(work_ff[0], 12);
      ss1 = rotl32(a12 + work_ff[4] + t_rot(round_ff), 7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ffv = work_ff[0] ^ work_ff[1] ^ work_ff[2];
         ggv = work_ff[4] ^ work_ff[5] ^ work_ff[6];
      end else begin
         ffv = (work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
             | (work_ff[1] & work_ff[2]);
         ggv = (work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]);
      end
      tt1 = ffv + work_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2 = ggv + work_ff[7] + ss1 + win_ff[0];

      work_in[0] = tt1;
      work_in[1] = work_ff[0];
      work_in[2] = rotl32(work_ff[1], 9);
      work_in[3] = work_ff[2];
      work_in[4] = p0(tt2);
      work_in[5] = work_ff[4];
      work_in[6] = rotl32(work_ff[5], 19);
      work_in[7] = work_ff[6];

      w_new  = p1(win_ff[0] ^ win_ff[7] ^ rotl32(win_ff[13], 15))
             ^ rotl32(win_ff[3], 7) ^ win_ff[10];
      win_in = {w_new, win_ff[15:1]};

      busy_in  = busy_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      if (ctl.init) begin
         chain_in = SM3_IV;
      end
      if (ctl.start) begin
         busy_in  = 1'b1;
         round_in = '0;
      end else if (busy_ff) begin
         round_in = round_ff + 6'd1;
         if (round_ff == 6'(ROUNDS - 1)) begin
            busy_in  = 1'b0;
            chain_in = chain_ff ^ work_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= '0;
         chain_ff <= SM3_IV;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         work_ff <= chain_ff;
         win_ff  <= block;
      end else if (busy_ff) begin
         work_ff <= work_in;
         win_ff  <= win_in;
      end
   end

   assign busy  = busy_ff;
   assign chain = chain_ff;

endmodule

// ===== rtl/sm3_chk.sv =====
// Port-level checks on the digest output of the SM3 hash engine, bound to
// sm3_hash_engine. Depends on sm3_hash_engine.
module sm3_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] digest_word,
   input logic [2:0]  word_index,
   input logic        last_word
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("digest item valid right after reset");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_word == (word_index == 3'd7)))
      else $error("last_word does not match word_index 7");

   a_first_index: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (word_index == 3'd0))
      else $error("digest does not start at word 0");

   a_next_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last_word)
      |=> (rsp_valid && word_index == $past(word_index) + 3'd1))
      else $error("digest words not contiguous");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready)
      |=> (rsp_valid && $stable(digest_word) && $stable(word_index)))
      else $error("stalled digest item changed");

endmodule

bind sm3_hash_engine sm3_chk u_sm3_chk (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .digest_word (rsp_if.digest_word),
   .word_index  (rsp_if.word_index),
   .last_word   (rsp_if.last_word)
);

// ===== dv/sm3_tb_pkg.sv =====
`timescale 1ns / 1ps
// Digest predictor and checker for the SM3 hash engine testbench.
// Self-contained SM3 model; no dependency on the RTL package.
package sm3_tb_pkg;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_entry_type;

   class sm3_digest_predictor;
      logic [31:0]      chain[8];
      logic [7:0]       msg_block[64];
      int               fill;
      logic [63:0]      bit_count;
      digest_entry_type expected_digest_q[$];
      int               errors;
      int               messages;
      int               spill_messages;
      int               words_checked;

      function new();
         errors         = 0;
         messages       = 0;
         spill_messages = 0;
         words_checked  = 0;
         restart();
      endfunction

      function void restart();
         chain = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                   32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};
         foreach (msg_block[i]) msg_block[i] = 8'h00;
         fill      = 0;
         bit_count = 64'd0;
      endfunction

      function logic [31:0] rol(logic [31:0] x, int n);
         int m;
         m = n % 32;
         if (m == 0) return x;
         return (x << m) | (x >> (32 - m));
      endfunction

      function logic [31:0] mix0(logic [31:0] x);
         return x ^ rol(x, 9) ^ rol(x, 17);
      endfunction

      function logic [31:0] mix1(logic [31:0] x);
         return x ^ rol(x, 15) ^ rol(x, 23);
      endfunction

      function void compress();
         logic [31:0] w[68];
         logic [31:0] a, b, c, d, e, f, g, h;
         logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
         for (int j = 0; j < 16; j++)
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
         for (int j = 16; j < 68; j++)
            w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
         {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                     chain[4], chain[5], chain[6], chain[7]};
         for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
            a12 = rol(a, 12);
            ss1 = rol(a12 + e + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
               ff = a ^ b ^ c;
               gg = e ^ f ^ g;
            end else begin
               ff = (a & b) | (a & c) | (b & c);
               gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c;
            c = rol(b, 9);
            b = a;
            a = tt1;
            h = g;
            g = rol(f, 19);
            f = e;
            e = mix0(tt2);
         end
         chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
         chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
      endfunction

      function void add_byte(logic [7:0] value);
         msg_block[fill] = value;
         fill++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      endfunction

      // one accepted message word; a word marked last queues the eight digest words
      function void note_word(logic [31:0] data, logic [2:0] nbytes, logic fin);
         int               count;
         digest_entry_type ent;
         count = (nbytes > 3'd4) ? 4 : int'(nbytes);
         for (int i = 0; i < count; i++)
            add_byte(data[31 - 8*i -: 8]);
         bit_count += 64'(count * 8);
         if (!fin) return;
         add_byte(8'h80);
         if (fill > 56) begin
            while (fill < 64) begin
               msg_block[fill] = 8'h00;
               fill++;
            end
            compress();
            fill = 0;
            spill_messages++;
         end
         while (fill < 56) begin
            msg_block[fill] = 8'h00;
            fill++;
         end
         for (int i = 0; i < 8; i++)
            msg_block[56 + i] = bit_count[63 - 8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++) begin
            ent.digest_word = chain[i];
            ent.word_index  = 3'(i);
            ent.last_word   = (i == 7);
            expected_digest_q.push_back(ent);
         end
         messages++;
         restart();
      endfunction

      function void check_digest_word(logic [31:0] digest, logic [2:0] index, logic fin);
         digest_entry_type ent;
         if (expected_digest_q.size() == 0) begin
            $display("%0t: unexpected digest word, actual %h index %0d last %b",
                     $time, digest, index, fin);
            errors++;
            return;
         end
         ent = expected_digest_q.pop_front();
         words_checked++;
         if (digest !== ent.digest_word) begin
            $display("%0t: digest_word mismatch, expected %h actual %h",
                     $time, ent.digest_word, digest);
            errors++;
         end
         if (index !== ent.word_index) begin
            $display("%0t: word_index mismatch, expected %0d actual %0d",
                     $time, ent.word_index, index);
            errors++;
         end
         if (fin !== ent.last_word) begin
            $display("%0t: last_word mismatch, expected %b actual %b",
                     $time, ent.last_word, fin);
            errors++;
         end
      endfunction

      function int pending();
         return expected_digest_q.size();
      endfunction
   endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the SM3 hash engine testbench: clock, reset, word driver, digest monitor.
// Uses sm3_if, sm3_hash_engine and sm3_tb_pkg.
module tb_top;
   import sm3_tb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   word_count  = 0;
   int   hold_left   = 0;
   int   mode_left   = 0;
   bit   rsp_calm    = 0;

   sm3_digest_predictor digest_model = new();

   sm3_req_if req_if ();
   sm3_rsp_if rsp_if ();

   sm3_hash_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sm3_hash_engine test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         digest_model.check_digest_word(rsp_if.digest_word, rsp_if.word_index,
                                        rsp_if.last_word);
   end

   // digest side back-pressure: calm stretches and random stalls
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rsp_calm  = ($urandom_range(0, 3) == 0);
         mode_left = $urandom_range(100, 400);
      end else begin
         mode_left--;
      end
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 5) == 0)
            hold_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 30);
      end
   end

   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(input logic [31:0] data, input logic [2:0] nbytes,
                            input logic fin, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.data_word   <= data;
      req_if.valid_bytes <= nbytes;
      req_if.last        <= fin;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      digest_model.note_word(data, nbytes, fin);
      word_count++;
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (digest_model.pending() != 0) @(posedge clock);
   endtask

   task automatic send_message(input int words);
      bit         burst;
      int         r;
      logic [2:0] nbytes;
      burst = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < words; k++) begin
         r = $urandom_range(0, 99);
         if (k == words - 1) nbytes = 3'($urandom_range(0, 7));
         else if (r < 85)    nbytes = 3'd4;
         else if (r < 92)    nbytes = 3'($urandom_range(5, 7));
         else                nbytes = 3'($urandom_range(0, 3));
         send_word($urandom, nbytes, k == words - 1, pick_gap(burst));
      end
   endtask

   initial begin
      int rand_words;
      int len;
      int r;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.data_word   = 32'd0;
      req_if.valid_bytes = 3'd0;
      req_if.last        = 1'b0;
      rsp_if.ready       = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty message, then "abc"
      send_word(32'h0000_0000, 3'd0, 1'b1, 0);
      send_word(32'h6162_6300, 3'd3, 1'b1, 0);
      // counts above four, short words mid-message, zero-byte word
      send_word($urandom, 3'd5, 1'b0, 1);
      send_word($urandom, 3'd2, 1'b0, 0);
      send_word($urandom, 3'd6, 1'b0, 0);
      send_word($urandom, 3'd0, 1'b0, 2);
      send_word($urandom, 3'd7, 1'b1, 0);
      wait_drain();
      // 60 bytes: pad spills into an extra block
      for (int k = 0; k < 14; k++)
         send_word((k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'd4, 1'b0, 0);
      send_word(32'hFFFF_FFFF, 3'd4, 1'b1, 0);
      wait_drain();

      rand_words = 0;
      while (rand_words < 195) begin
         r = $urandom_range(0, 99);
         if (r < 50)      len = $urandom_range(1, 8);
         else if (r < 80) len = $urandom_range(13, 18);
         else if (r < 95) len = $urandom_range(9, 12);
         else             len = $urandom_range(30, 40);
         send_message(len);
         rand_words += len;
         if ($urandom_range(0, 6) == 0) wait_drain();
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      wait_drain();
      repeat (200) @(posedge clock);
      if (digest_model.pending() != 0) begin
         $display("%0t: %0d digest words never arrived", $time, digest_model.pending());
         digest_model.errors++;
      end
      $display("Covered %0d message words in %0d messages (%0d with an extra pad block),",
               word_count, digest_model.messages, digest_model.spill_messages);
      $display("%0d digest words compared, %0d mismatches", digest_model.words_checked,
               digest_model.errors);
      if (digest_model.errors == 0) begin
         $display("sm3_hash_engine test passed");
      end else begin
         $display("sm3_hash_engine test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sm3_pkg.sv
rtl/sm3_if.sv
rtl/sm3_comp.sv
rtl/sm3_hash_engine.sv
rtl/sm3_chk.sv
dv/sm3_tb_pkg.sv
dv/tb_top.sv
